// File: rtl/ctt_pkg.sv
// Shared types and character codes for the configuration text tokenizer.
package ctt_pkg;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;

   localparam int CMD_FIFO_DEPTH = 4;
   localparam int RSP_FIFO_DEPTH = 4;

   localparam int OFFSET_WIDTH = 24;
   localparam int LENGTH_WIDTH = 25;
   localparam int DEPTH_WIDTH  = 8;

   typedef enum logic [2:0] {
      EV_KEY   = 3'd0,
      EV_VALUE = 3'd1,
      EV_OPEN  = 3'd2,
      EV_CLOSE = 3'd3,
      EV_END   = 3'd4
   } ctt_kind_type;

   typedef struct packed {
      logic has_token;
      logic is_close;
      logic is_open;
      logic has_end;
   } ctt_flags_type;

   typedef struct packed {
      ctt_kind_type              event_kind;
      logic [OFFSET_WIDTH-1:0]   token_offset;
      logic [LENGTH_WIDTH-1:0]   token_length;
      logic [DEPTH_WIDTH-1:0]    property_depth;
      logic                      final_event;
   } ctt_rsp_type;

endpackage

// File: rtl/ctt_fifo.sv
// Small first-in first-out queue with combinational head read.
module ctt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [ADDR_BITS-1:0] wr_ptr_ff;
   logic [ADDR_BITS-1:0] wr_ptr_in;
   logic [ADDR_BITS-1:0] rd_ptr_ff;
   logic [ADDR_BITS-1:0] rd_ptr_in;
   logic [ADDR_BITS:0]   count_ff;
   logic [ADDR_BITS:0]   count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (count_ff == (ADDR_BITS+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/ctt_front.sv
// Byte scanner: tracks comments and token bounds and queues finished tokens.
module ctt_front #(
   parameter int POSITION_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic [7:0]                req_text_byte,
   input  logic                      req_end_of_text,
   output logic                      req_full,
   output logic                      cmd_push,
   output ctt_pkg::ctt_flags_type    cmd_flags,
   output logic [POSITION_BITS-1:0]  cmd_offset,
   output logic [POSITION_BITS:0]    cmd_length,
   output logic [POSITION_BITS-1:0]  cmd_end_offset,
   input  logic                      cmd_full
);

   localparam logic [POSITION_BITS:0] SIZE_LIMIT = {1'b1, {POSITION_BITS{1'b0}}};
   localparam logic [POSITION_BITS:0] SIZE_ONE   = (POSITION_BITS+1)'(1);

   logic                     in_comment_ff;
   logic                     in_comment_in;
   logic                     in_token_ff;
   logic                     in_token_in;
   logic [POSITION_BITS-1:0] token_begin_ff;
   logic [POSITION_BITS-1:0] token_begin_in;
   logic [POSITION_BITS:0]   token_size_ff;
   logic [POSITION_BITS:0]   token_size_in;
   logic [7:0]               first_char_ff;
   logic [7:0]               first_char_in;
   logic [POSITION_BITS-1:0] position_ff;
   logic                     delim;
   logic                     accept;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   always_comb begin
      in_comment_in = in_comment_ff;
      if (req_text_byte == ctt_pkg::CHAR_SEMICOLON) begin
         in_comment_in = 1'b1;
      end else if (req_text_byte == ctt_pkg::CHAR_LF) begin
         in_comment_in = 1'b0;
      end
      delim = in_comment_in || (req_text_byte inside {ctt_pkg::CHAR_TAB, ctt_pkg::CHAR_LF,
         ctt_pkg::CHAR_CR, ctt_pkg::CHAR_SPACE, ctt_pkg::CHAR_NUL});

      in_token_in    = in_token_ff;
      token_begin_in = token_begin_ff;
      token_size_in  = token_size_ff;
      first_char_in  = first_char_ff;
      if (delim) begin
         in_token_in = 1'b0;
      end else if (!in_token_ff) begin
         in_token_in    = 1'b1;
         token_begin_in = position_ff;
         token_size_in  = SIZE_ONE;
         first_char_in  = req_text_byte;
      end else if (token_size_ff != SIZE_LIMIT) begin
         token_size_in = token_size_ff + SIZE_ONE;
      end

      cmd_flags.has_token = (delim && in_token_ff) || (req_end_of_text && in_token_in);
      cmd_flags.is_close  = (token_size_in == SIZE_ONE) && (first_char_in == ctt_pkg::CHAR_RBRACE);
      cmd_flags.is_open   = (token_size_in == SIZE_ONE) && (first_char_in == ctt_pkg::CHAR_LBRACE);
      cmd_flags.has_end   = req_end_of_text;
   end

   assign cmd_push       = accept && (cmd_flags.has_token || cmd_flags.has_end);
   assign cmd_offset     = token_begin_in;
   assign cmd_length     = token_size_in;
   assign cmd_end_offset = position_ff;

   always_ff @(posedge clock) begin
      if (reset || (accept && req_end_of_text)) begin
         in_comment_ff  <= 1'b0;
         in_token_ff    <= 1'b0;
         token_begin_ff <= '0;
         token_size_ff  <= '0;
         first_char_ff  <= '0;
         position_ff    <= '0;
      end else if (accept) begin
         in_comment_ff  <= in_comment_in;
         in_token_ff    <= in_token_in;
         token_begin_ff <= token_begin_in;
         token_size_ff  <= token_size_in;
         first_char_ff  <= first_char_in;
         position_ff    <= position_ff + 1'b1;
      end
   end

endmodule

// File: rtl/ctt_back.sv
// Property builder: assigns key/value roles, tracks depth and emits events.
module ctt_back #(
   parameter int POSITION_BITS = 24,
   parameter int DEPTH_BITS    = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_empty,
   output logic                      cmd_pop,
   input  ctt_pkg::ctt_flags_type    cmd_flags,
   input  logic [POSITION_BITS-1:0]  cmd_offset,
   input  logic [POSITION_BITS:0]    cmd_length,
   input  logic [POSITION_BITS-1:0]  cmd_end_offset,
   output logic                      rsp_push,
   output ctt_pkg::ctt_rsp_type      rsp_data,
   input  logic                      rsp_full
);

   localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

   logic                          key_seen_ff;
   logic                          key_seen_in;
   logic signed [DEPTH_BITS-1:0]  depth_ff;
   logic signed [DEPTH_BITS-1:0]  depth_in;
   logic                          phase_ff;
   logic                          phase_in;
   logic                          work;
   logic                          emit_end;
   ctt_pkg::ctt_kind_type         kind;
   logic signed [63:0]            depth_ext;
   logic [63:0]                   offset_ext;
   logic [63:0]                   length_ext;

   assign work     = !cmd_empty && !rsp_full;
   assign emit_end = !cmd_flags.has_token || phase_ff;
   assign rsp_push = work;

   always_comb begin
      key_seen_in = key_seen_ff;
      depth_in    = depth_ff;
      phase_in    = phase_ff;
      cmd_pop     = 1'b0;
      kind        = ctt_pkg::EV_END;
      if (work) begin
         if (!emit_end) begin
            if (cmd_flags.is_close) begin
               kind = ctt_pkg::EV_CLOSE;
               if (depth_ff != DEPTH_MIN) begin
                  depth_in = depth_ff - DEPTH_ONE;
               end
            end else if (!key_seen_ff) begin
               kind        = ctt_pkg::EV_KEY;
               key_seen_in = 1'b1;
            end else begin
               key_seen_in = 1'b0;
               if (cmd_flags.is_open) begin
                  kind = ctt_pkg::EV_OPEN;
                  if (depth_ff != DEPTH_MAX) begin
                     depth_in = depth_ff + DEPTH_ONE;
                  end
               end else begin
                  kind = ctt_pkg::EV_VALUE;
               end
            end
            if (cmd_flags.has_end) begin
               phase_in = 1'b1;
            end else begin
               cmd_pop = 1'b1;
            end
         end else begin
            key_seen_in = 1'b0;
            depth_in    = '0;
            phase_in    = 1'b0;
            cmd_pop     = 1'b1;
         end
      end
   end

   assign depth_ext  = emit_end ? 64'(depth_ff) : 64'(depth_in);
   assign offset_ext = emit_end ? 64'(cmd_end_offset) : 64'(cmd_offset);
   assign length_ext = emit_end ? '0 : 64'(cmd_length);

   always_comb begin
      rsp_data.event_kind     = kind;
      rsp_data.token_offset   = offset_ext[ctt_pkg::OFFSET_WIDTH-1:0];
      rsp_data.token_length   = length_ext[ctt_pkg::LENGTH_WIDTH-1:0];
      rsp_data.property_depth = depth_ext[ctt_pkg::DEPTH_WIDTH-1:0];
      rsp_data.final_event    = emit_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_seen_ff <= 1'b0;
         depth_ff    <= '0;
         phase_ff    <= 1'b0;
      end else begin
         key_seen_ff <= key_seen_in;
         depth_ff    <= depth_in;
         phase_ff    <= phase_in;
      end
   end

endmodule

// File: rtl/config_text_tokenizer.sv
// Top level of the configuration text tokenizer: scanner, token queue, builder, event queue.
// A token event passes through the token queue and the event queue before it is visible.
// The end event follows the token event when the final byte also ends a token.
// Throughput: one byte per cycle while req_full is low; the final byte of a text
// that ends a token makes the builder emit a token event and then the end event.
// Reset: synchronous, clears scanner, builder and both queues.
module config_text_tokenizer #(
   parameter int POSITION_BITS = 24,
   parameter int DEPTH_BITS    = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_event_kind,
   output logic [23:0] rsp_token_offset,
   output logic [24:0] rsp_token_length,
   output logic [7:0]  rsp_property_depth,
   output logic        rsp_final_event
);

   localparam int FLAG_BITS = $bits(ctt_pkg::ctt_flags_type);
   localparam int CMD_WIDTH = FLAG_BITS + 3 * POSITION_BITS + 1;
   localparam int RSP_WIDTH = $bits(ctt_pkg::ctt_rsp_type);

   logic                     cmd_push;
   logic                     cmd_full;
   logic                     cmd_pop;
   logic                     cmd_empty;
   ctt_pkg::ctt_flags_type   front_flags;
   logic [POSITION_BITS-1:0] front_offset;
   logic [POSITION_BITS:0]   front_length;
   logic [POSITION_BITS-1:0] front_end_offset;
   ctt_pkg::ctt_flags_type   back_flags;
   logic [POSITION_BITS-1:0] back_offset;
   logic [POSITION_BITS:0]   back_length;
   logic [POSITION_BITS-1:0] back_end_offset;
   logic [CMD_WIDTH-1:0]     cmd_head;
   logic                     rsp_push;
   logic                     rsp_full;
   ctt_pkg::ctt_rsp_type     rsp_in;
   logic [RSP_WIDTH-1:0]     rsp_head;
   ctt_pkg::ctt_rsp_type     rsp_out;

   ctt_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .req_full        (req_full),
      .cmd_push        (cmd_push),
      .cmd_flags       (front_flags),
      .cmd_offset      (front_offset),
      .cmd_length      (front_length),
      .cmd_end_offset  (front_end_offset),
      .cmd_full        (cmd_full)
   );

   ctt_fifo #(
      .WIDTH (CMD_WIDTH),
      .DEPTH (ctt_pkg::CMD_FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data ({front_flags, front_offset, front_length, front_end_offset}),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .empty     (cmd_empty)
   );

   assign {back_flags, back_offset, back_length, back_end_offset} = cmd_head;

   ctt_back #(
      .POSITION_BITS (POSITION_BITS),
      .DEPTH_BITS    (DEPTH_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_empty      (cmd_empty),
      .cmd_pop        (cmd_pop),
      .cmd_flags      (back_flags),
      .cmd_offset     (back_offset),
      .cmd_length     (back_length),
      .cmd_end_offset (back_end_offset),
      .rsp_push       (rsp_push),
      .rsp_data       (rsp_in),
      .rsp_full       (rsp_full)
   );

   ctt_fifo #(
      .WIDTH (RSP_WIDTH),
      .DEPTH (ctt_pkg::RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_out            = rsp_head;
   assign rsp_event_kind     = rsp_out.event_kind;
   assign rsp_token_offset   = rsp_out.token_offset;
   assign rsp_token_length   = rsp_out.token_length;
   assign rsp_property_depth = rsp_out.property_depth;
   assign rsp_final_event    = rsp_out.final_event;

endmodule
